// ----- hw/rtl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// Bytecode stack engine package
// Shared transaction types, command codes and status codes for the data stack.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int KIND_W          = 3;
    localparam int STATUS_W        = 3;
    localparam int DEPTH_W         = 7;

    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SWAP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ADD_SHORT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        logic [DEPTH_W-1:0]       depth;
    } rsp_t;

endpackage

// ----- hw/rtl/bse_engine.sv -----
// ----------------------------------------------------------------------------
// Bytecode stack engine execution unit
// Ring-buffer entry memory with a cached top value and the command sequencer.
// ----------------------------------------------------------------------------
module bse_engine #(
    parameter int STACK_DEPTH = bse_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  bse_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_take,
    output bse_pkg::rsp_t res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int DW = bse_pkg::DEPTH_W;
    localparam int XW = bse_pkg::DATA_W;

    localparam logic [AW-1:0] LAST_SLOT  = AW'(STACK_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
    localparam logic [SW-1:0] RING_SIZE  = SW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP2
    } state_t;

    state_t                      state_reg, state_next;
    logic [bse_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [XW-1:0]               value_reg, value_next;
    logic [AW-1:0]               top_reg, top_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [XW-1:0]               head_reg, head_next;

    logic [XW-1:0]               entry_mem [STACK_DEPTH];
    logic [XW-1:0]               rdata_reg;

    logic                        wr_en;
    logic [AW-1:0]               waddr;
    logic [XW-1:0]               wdata;

    logic [AW-1:0]               next_slot;
    logic [AW-1:0]               prev_slot;
    logic [SW-1:0]               bottom_sum;
    logic [AW-1:0]               bottom_slot;
    logic                        is_full;
    logic                        is_empty;
    logic                        has_two;
    logic [XW-1:0]               sum;
    logic [bse_pkg::STATUS_W-1:0] status;

    assign next_slot   = (top_reg == LAST_SLOT) ? '0 : top_reg + AW'(1);
    assign prev_slot   = (top_reg == '0) ? LAST_SLOT : top_reg - AW'(1);
    assign bottom_sum  = SW'(top_reg) + SW'(count_reg);
    assign bottom_slot = (bottom_sum >= RING_SIZE) ? AW'(bottom_sum - RING_SIZE)
                                                   : AW'(bottom_sum);
    assign is_full     = (count_reg == FULL_COUNT);
    assign is_empty    = (count_reg == '0);
    assign has_two     = (count_reg > CW'(1));
    assign sum         = head_reg + rdata_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        top_next   = top_reg;
        count_next = count_reg;
        head_next  = head_reg;
        wr_en      = 1'b0;
        waddr      = top_reg;
        wdata      = value_reg;
        status     = bse_pkg::ST_OK;
        res_valid  = 1'b0;
        cmd_stall  = (state_reg != S_IDLE);
        res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next  = cmd.kind;
                    value_next = cmd.value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
                unique case (kind_reg)
                    bse_pkg::KIND_PUSH:
                    begin
                        if (is_full)
                        begin
                            status = bse_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            waddr      = prev_slot;
                            top_next   = prev_slot;
                            head_next  = value_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    bse_pkg::KIND_APPEND:
                    begin
                        if (is_full)
                        begin
                            status = bse_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            waddr      = bottom_slot;
                            count_next = count_reg + CW'(1);
                            if (is_empty)
                            begin
                                head_next = value_reg;
                            end
                        end
                    end
                    bse_pkg::KIND_POP:
                    begin
                        if (is_empty)
                        begin
                            status = bse_pkg::ST_POP_EMPTY;
                        end
                        else
                        begin
                            top_next   = next_slot;
                            head_next  = rdata_reg;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    bse_pkg::KIND_SWAP:
                    begin
                        if (!has_two)
                        begin
                            status = bse_pkg::ST_SWAP_SHORT;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            waddr      = top_reg;
                            wdata      = rdata_reg;
                            head_next  = rdata_reg;
                            value_next = head_reg;
                            state_next = S_SWAP2;
                        end
                    end
                    bse_pkg::KIND_ADD:
                    begin
                        if (!has_two)
                        begin
                            status = bse_pkg::ST_ADD_SHORT;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            waddr      = next_slot;
                            wdata      = sum;
                            top_next   = next_slot;
                            head_next  = sum;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default:
                    begin
                        status = bse_pkg::ST_OK;
                    end
                endcase

                res.status    = status;
                res.top_valid = (count_next != '0);
                res.top_value = (count_next != '0) ? head_next : '0;
                res.depth     = DW'(count_next);

                if (!res_take)
                begin
                    state_next = state_reg;
                    value_next = value_reg;
                    top_next   = top_reg;
                    count_next = count_reg;
                    head_next  = head_reg;
                    wr_en      = 1'b0;
                end
            end
            S_SWAP2:
            begin
                wr_en      = 1'b1;
                waddr      = next_slot;
                wdata      = value_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        head_reg  <= head_next;
    end

    // The second entry is read while idle, so it is ready when a command executes.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (state_reg == S_IDLE)
        begin
            rdata_reg <= entry_mem[next_slot];
        end
    end

endmodule

// ----- hw/rtl/bytecode_stack_engine_core.sv -----
// ----------------------------------------------------------------------------
// Bytecode stack engine
// Data stack of a bytecode interpreter held as a bounded ring of entries.
// ----------------------------------------------------------------------------
// The cmd channel carries one command per transaction: push on top, append at
// the bottom, pop, swap the top two, or add the top two. Every command yields
// exactly one transaction on the rsp channel with a status, the top value, a
// top-valid flag and the depth after the command.
// A command is accepted when cmd_valid is high and cmd_stall is low. Its
// response is registered onto rsp from S_EXEC once rsp is free.
// A command first reads the second entry from the entry memory in S_IDLE,
// then executes and writes back in S_EXEC. A successful swap adds S_SWAP2,
// since the single write port of the entry memory stores both entries.
// The next command is accepted while a response still waits in the output
// register; execution holds only when that register is full and stalled.
// Reset empties the stack at once and clears rsp_valid; the entry memory
// itself is not cleared. While a valid rsp is stalled, rsp_valid and rsp
// hold, and at most one further command is accepted and held in execution.
// ----------------------------------------------------------------------------
module bytecode_stack_engine_core #(
    parameter int STACK_DEPTH = bse_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  bse_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bse_pkg::rsp_t rsp
);

    logic          res_valid;
    logic          res_take;
    bse_pkg::rsp_t res;

    logic          rsp_valid_reg;
    bse_pkg::rsp_t rsp_reg;

    bse_engine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("Command accepted on two consecutive cycles.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == bse_pkg::ST_OK || rsp.status == bse_pkg::ST_POP_EMPTY
            || rsp.status == bse_pkg::ST_SWAP_SHORT || rsp.status == bse_pkg::ST_ADD_SHORT
            || rsp.status == bse_pkg::ST_FULL))
        else $error("Response carries an undefined status.");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.top_valid) |-> (rsp.top_value == '0))
        else $error("Empty stack reports a nonzero top value.");

    a_depth_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (STACK_DEPTH < 128)) |-> (rsp.top_valid == (rsp.depth != '0)))
        else $error("Top-valid flag disagrees with the depth.");

endmodule

// ----- verif/bytecode_stack_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// Bytecode stack engine testbench
// Drives push, append, pop, swap, add and unused commands into the data
// stack. Random idling is applied on both channels. Each response is checked
// field by field against a behavioral model of the ring-based stack.
// ----------------------------------------------------------------------------
module bytecode_stack_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_SLOTS = bse_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [bse_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [bse_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    bse_pkg::cmd_t  cmd = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    bse_pkg::rsp_t  rsp;

    logic  cmd_taken = 1'b0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    gen_depth = 0;

    bse_pkg::cmd_t  cmd_pending[$];
    bse_pkg::rsp_t  stack_expect[$];

    logic [bse_pkg::DATA_W-1:0]  ring_mem [STACK_SLOTS];
    logic [5:0]                  ring_top = '0;
    logic [bse_pkg::DEPTH_W-1:0] ring_count = '0;

    bytecode_stack_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    function automatic bse_pkg::rsp_t stack_apply(bse_pkg::cmd_t c);
        bse_pkg::rsp_t              r;
        logic [5:0]                 second;
        logic [bse_pkg::DATA_W-1:0] a;
        logic [bse_pkg::DATA_W-1:0] b;
        second = ring_top + 6'd1;
        r = '0;
        r.status = bse_pkg::ST_OK;
        case (c.kind)
            bse_pkg::KIND_PUSH:
                if (ring_count == STACK_SLOTS)
                begin
                    r.status = bse_pkg::ST_FULL;
                end
                else
                begin
                    ring_top = ring_top - 6'd1;
                    ring_mem[ring_top] = c.value;
                    ring_count = ring_count + 7'd1;
                end
            bse_pkg::KIND_APPEND:
                if (ring_count == STACK_SLOTS)
                begin
                    r.status = bse_pkg::ST_FULL;
                end
                else
                begin
                    ring_mem[6'(ring_top + ring_count[5:0])] = c.value;
                    ring_count = ring_count + 7'd1;
                end
            bse_pkg::KIND_POP:
                if (ring_count == 0)
                begin
                    r.status = bse_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    ring_top = second;
                    ring_count = ring_count - 7'd1;
                end
            bse_pkg::KIND_SWAP:
                if (ring_count < 2)
                begin
                    r.status = bse_pkg::ST_SWAP_SHORT;
                end
                else
                begin
                    a = ring_mem[ring_top];
                    b = ring_mem[second];
                    ring_mem[ring_top] = b;
                    ring_mem[second] = a;
                end
            bse_pkg::KIND_ADD:
                if (ring_count < 2)
                begin
                    r.status = bse_pkg::ST_ADD_SHORT;
                end
                else
                begin
                    ring_mem[second] = ring_mem[ring_top] + ring_mem[second];
                    ring_top = second;
                    ring_count = ring_count - 7'd1;
                end
            default:
                ;
        endcase
        r.top_valid = (ring_count != 0);
        r.top_value = r.top_valid ? ring_mem[ring_top] : '0;
        r.depth = ring_count;
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_valid || cmd_taken)
            begin
                if (cmd_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd <= cmd_pending.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        bse_pkg::rsp_t want;
        cmd_taken <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
            stack_expect.push_back(stack_apply(cmd));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (stack_expect.size() == 0)
            begin
                report_error("response transaction with no command outstanding");
            end
            else
            begin
                want = stack_expect.pop_front();
                if (rsp.status !== want.status)
                    report_error($sformatf("status: got %0d, want %0d",
                                           rsp.status, want.status));
                if (rsp.top_value !== want.top_value)
                    report_error($sformatf("top_value: got %08h, want %08h",
                                           rsp.top_value, want.top_value));
                if (rsp.top_valid !== want.top_valid)
                    report_error($sformatf("top_valid: got %0b, want %0b",
                                           rsp.top_valid, want.top_valid));
                if (rsp.depth !== want.depth)
                    report_error($sformatf("depth: got %0d, want %0d",
                                           rsp.depth, want.depth));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_cmd(logic [bse_pkg::KIND_W-1:0] k, logic [bse_pkg::DATA_W-1:0] v);
        bse_pkg::cmd_t c;
        c.kind = k;
        c.value = v;
        cmd_pending.push_back(c);
        case (k)
            bse_pkg::KIND_PUSH, bse_pkg::KIND_APPEND:
                if (gen_depth < STACK_SLOTS) gen_depth++;
            bse_pkg::KIND_POP:
                if (gen_depth > 0) gen_depth--;
            bse_pkg::KIND_ADD:
                if (gen_depth >= 2) gen_depth--;
            default:
                ;
        endcase
    endtask

    function automatic logic [bse_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [bse_pkg::KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return bse_pkg::KIND_PUSH;
        if (r < 45) return bse_pkg::KIND_APPEND;
        if (r < 65) return bse_pkg::KIND_POP;
        if (r < 80) return bse_pkg::KIND_SWAP;
        if (r < 95) return bse_pkg::KIND_ADD;
        return KIND_SPARE_FIRST
            + bse_pkg::KIND_W'($urandom_range(0, KIND_SPARE_LAST - KIND_SPARE_FIRST));
    endfunction

    function automatic logic [bse_pkg::KIND_W-1:0] pick_grow();
        return $urandom_range(0, 1) ? bse_pkg::KIND_PUSH : bse_pkg::KIND_APPEND;
    endfunction

    function automatic logic [bse_pkg::KIND_W-1:0] pick_shrink();
        case ($urandom_range(0, 4))
            0, 1: return bse_pkg::KIND_POP;
            2, 3: return bse_pkg::KIND_ADD;
            default: return bse_pkg::KIND_SWAP;
        endcase
    endfunction

    task automatic queue_random(int count);
        int made;
        logic [bse_pkg::KIND_W-1:0] k;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    while (gen_depth < STACK_SLOTS)
                    begin
                        queue_cmd(pick_grow(), pick_value());
                        made++;
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        queue_cmd(pick_grow(), pick_value());
                        made++;
                    end
                end
                2, 3:
                begin
                    while (gen_depth > 0)
                    begin
                        queue_cmd(pick_shrink(), pick_value());
                        made++;
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        queue_cmd(pick_shrink(), pick_value());
                        made++;
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 24))
                    begin
                        k = pick_kind();
                        queue_cmd(k, pick_value());
                        if (k <= bse_pkg::KIND_ADD) made++;
                    end
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (cmd_pending.size() != 0 || cmd_valid || stack_expect.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        send_idle_pct = 32;
        recv_idle_pct = 69;

        queue_cmd(bse_pkg::KIND_POP, 32'h0);
        queue_cmd(bse_pkg::KIND_SWAP, 32'h0);
        queue_cmd(bse_pkg::KIND_ADD, 32'h0);
        queue_cmd(bse_pkg::KIND_PUSH, 32'h7FFF_FFFF);
        queue_cmd(bse_pkg::KIND_SWAP, 32'hFFFF_FFFF);
        queue_cmd(bse_pkg::KIND_ADD, 32'hFFFF_FFFF);
        queue_cmd(bse_pkg::KIND_PUSH, 32'h0000_0001);
        queue_cmd(bse_pkg::KIND_ADD, 32'h0);
        queue_cmd(bse_pkg::KIND_PUSH, 32'h8000_0000);
        queue_cmd(bse_pkg::KIND_PUSH, 32'hFFFF_FFFF);
        queue_cmd(bse_pkg::KIND_ADD, 32'h0);
        queue_cmd(bse_pkg::KIND_APPEND, 32'h0000_0000);
        queue_cmd(bse_pkg::KIND_APPEND, 32'hFFFF_FFFF);
        queue_cmd(bse_pkg::KIND_SWAP, 32'h0);
        queue_cmd(bse_pkg::KIND_POP, 32'h0);
        queue_cmd(KIND_SPARE_FIRST, 32'hFFFF_FFFF);
        queue_cmd(KIND_SPARE_FIRST + 3'd1, 32'h0);
        queue_cmd(KIND_SPARE_LAST, 32'hA5A5_5A5A);
        queue_cmd(bse_pkg::KIND_POP, 32'h0);
        queue_cmd(bse_pkg::KIND_POP, 32'h0);
        queue_cmd(bse_pkg::KIND_POP, 32'h0);
        queue_cmd(bse_pkg::KIND_POP, 32'h0);
        queue_cmd(bse_pkg::KIND_ADD, 32'h0);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        wait_drained();
        queue_random(430);
        wait_drained();

        send_idle_pct = 69;
        recv_idle_pct = 32;
        queue_random(430);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(440);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && stack_expect.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
